// File: rtl/tcfod_pkg.sv
// ----------------------------------------------------------------------------
// tcfod_pkg
// Shared types and constants for the two-class ordered-drain FIFO.
// ----------------------------------------------------------------------------
package tcfod_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int STAMP_BITS_DEF  = 16;

  localparam int ACTION_W    = 3;
  localparam int IDENT_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;  // action + ident, padded to bytes
  localparam int OUT_TDATA_W = 40;  // status + ident, padded to bytes

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD       = 3'd0,
    ACT_DRAIN_ALL = 3'd1,
    ACT_DRAIN_C0  = 3'd2,
    ACT_DRAIN_C1  = 3'd3,
    ACT_Q_BOTH    = 3'd4,
    ACT_Q_C0      = 3'd5,
    ACT_Q_C1      = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DRAINED = 2'd0,
    ST_YES     = 2'd1,
    ST_NO      = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    push;       // store input word in queue of its kind
    logic    stamp_inc;  // advance arrival stamp
    logic    emit;       // load output register
    status_t status;
    logic    kind;
    logic    use_id;     // output ident from input word
    logic    pop;        // output ident from head of pop_cls, advance head
    logic    pop_cls;
    logic    last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty0;
    logic empty1;
    logic full0;
    logic full1;
    logic one0;
    logic one1;
    logic older0;    // class 0 head strictly older than class 1 head
    logic out_free;  // output register can take a word this cycle
  } dp_sts_t;

endpackage

// File: rtl/tcfod_queue.sv
// ----------------------------------------------------------------------------
// tcfod_queue
// Circular buffer of one class: identifier and arrival stamp per entry.
// ----------------------------------------------------------------------------
module tcfod_queue #(
  parameter int QUEUE_DEPTH = tcfod_pkg::QUEUE_DEPTH_DEF,
  parameter int STAMP_BITS  = tcfod_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          pop,
  input  logic [tcfod_pkg::IDENT_W-1:0] wr_id,
  input  logic [STAMP_BITS-1:0]         wr_stamp,
  output logic [tcfod_pkg::IDENT_W-1:0] head_id,
  output logic [STAMP_BITS-1:0]         head_stamp,
  output logic                          empty,
  output logic                          full,
  output logic                          one
);
  import tcfod_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [IDENT_W-1:0]    ids_r    [QUEUE_DEPTH];
  logic [STAMP_BITS-1:0] stamps_r [QUEUE_DEPTH];
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [IDX_W:0]        tail_sum;
  logic [IDX_W-1:0]      tail;

  assign tail_sum = (IDX_W+1)'(head_r) + (IDX_W+1)'(fill_r);
  assign tail     = (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH))
                    ? IDX_W'(tail_sum - (IDX_W+1)'(QUEUE_DEPTH))
                    : IDX_W'(tail_sum);

  assign empty      = (fill_r == '0);
  assign full       = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign one        = (fill_r == FILL_W'(1));
  assign head_id    = ids_r[head_r];
  assign head_stamp = stamps_r[head_r];

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (push && !full) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !empty) begin
      fill_nxt = fill_r - FILL_W'(1);
      head_nxt = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ids_r[tail]    <= wr_id;
      stamps_r[tail] <= wr_stamp;
    end
  end

endmodule

// File: rtl/tcfod_datapath.sv
// ----------------------------------------------------------------------------
// tcfod_datapath
// Both class queues, shared arrival stamp, head ordering and output register.
// ----------------------------------------------------------------------------
module tcfod_datapath #(
  parameter int QUEUE_DEPTH = tcfod_pkg::QUEUE_DEPTH_DEF,
  parameter int STAMP_BITS  = tcfod_pkg::STAMP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcfod_pkg::dp_cmd_t               cmd,
  output tcfod_pkg::dp_sts_t               sts,
  input  logic                             in_kind,
  input  logic [tcfod_pkg::IDENT_W-1:0]    in_ident,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tcfod_pkg::status_t               out_status,
  output logic                             out_kind,
  output logic [tcfod_pkg::IDENT_W-1:0]    out_ident,
  output logic                             out_last
);
  import tcfod_pkg::*;

  logic [STAMP_BITS-1:0] stamp_r;
  logic [IDENT_W-1:0]    head_id0, head_id1;
  logic [STAMP_BITS-1:0] head_st0, head_st1, stamp_diff;
  logic                  empty0, empty1, full0, full1, one0, one1;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic                  out_kind_r;
  logic [IDENT_W-1:0]    out_ident_r;
  logic                  out_last_r;
  logic [IDENT_W-1:0]    emit_id;

  tcfod_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .STAMP_BITS(STAMP_BITS)) u_q0 (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd.push && !in_kind),
    .pop        (cmd.pop && !cmd.pop_cls),
    .wr_id      (in_ident),
    .wr_stamp   (stamp_r),
    .head_id    (head_id0),
    .head_stamp (head_st0),
    .empty      (empty0),
    .full       (full0),
    .one        (one0)
  );

  tcfod_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .STAMP_BITS(STAMP_BITS)) u_q1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd.push && in_kind),
    .pop        (cmd.pop && cmd.pop_cls),
    .wr_id      (in_ident),
    .wr_stamp   (stamp_r),
    .head_id    (head_id1),
    .head_stamp (head_st1),
    .empty      (empty1),
    .full       (full1),
    .one        (one1)
  );

  // wrapped compare: sign of the modular difference
  assign stamp_diff = head_st0 - head_st1;

  always_comb begin
    sts.empty0   = empty0;
    sts.empty1   = empty1;
    sts.full0    = full0;
    sts.full1    = full1;
    sts.one0     = one0;
    sts.one1     = one1;
    sts.older0   = stamp_diff[STAMP_BITS-1];
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    if (cmd.pop) begin
      emit_id = cmd.pop_cls ? head_id1 : head_id0;
    end else if (cmd.use_id) begin
      emit_id = in_ident;
    end else begin
      emit_id = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.stamp_inc) begin
        stamp_r <= stamp_r + STAMP_BITS'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_kind_r   <= cmd.kind;
      out_ident_r  <= emit_id;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_kind   = out_kind_r;
  assign out_ident  = out_ident_r;
  assign out_last   = out_last_r;

endmodule

// File: rtl/tcfod_ctrl.sv
// ----------------------------------------------------------------------------
// tcfod_ctrl
// Command decode and drain sequencer: one pop per cycle while draining and the output is free.
// ----------------------------------------------------------------------------
module tcfod_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  tcfod_pkg::action_t   action,
  input  logic                 kind,
  input  tcfod_pkg::dp_sts_t   sts,
  output logic                 in_ready,
  output tcfod_pkg::dp_cmd_t   cmd
);
  import tcfod_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    M_ALL,
    M_C0,
    M_C1
  } mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   accept;
  logic   pick;
  logic   fin;
  logic   yes;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  // head selection; a stamp tie goes to class 1
  always_comb begin
    case (mode_r)
      M_ALL: begin
        pick = !(sts.empty1 || (!sts.empty0 && sts.older0));
        fin  = (sts.one0 && sts.empty1) || (sts.one1 && sts.empty0);
      end
      M_C0: begin
        pick = 1'b0;
        fin  = sts.one0;
      end
      M_C1: begin
        pick = 1'b1;
        fin  = sts.one1;
      end
      default: begin
        pick = 1'b0;
        fin  = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    yes       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_ADD: begin
              cmd.stamp_inc = 1'b1;
              if (kind ? sts.full1 : sts.full0) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_DROPPED;
                cmd.kind   = kind;
                cmd.use_id = 1'b1;
                cmd.last   = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
            end
            ACT_DRAIN_ALL: begin
              mode_nxt = M_ALL;
              if (!(sts.empty0 && sts.empty1)) begin
                state_nxt = S_DRAIN;
              end
            end
            ACT_DRAIN_C0: begin
              mode_nxt = M_C0;
              if (!sts.empty0) begin
                state_nxt = S_DRAIN;
              end
            end
            ACT_DRAIN_C1: begin
              mode_nxt = M_C1;
              if (!sts.empty1) begin
                state_nxt = S_DRAIN;
              end
            end
            ACT_Q_BOTH, ACT_Q_C0, ACT_Q_C1: begin
              if (action == ACT_Q_BOTH) begin
                yes = sts.empty0 && sts.empty1;
              end else if (action == ACT_Q_C0) begin
                yes = sts.empty0;
              end else begin
                yes = sts.empty1;
              end
              cmd.emit   = 1'b1;
              cmd.status = yes ? ST_YES : ST_NO;
              cmd.last   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.pop     = 1'b1;
          cmd.pop_cls = pick;
          cmd.kind    = pick;
          cmd.status  = ST_DRAINED;
          cmd.last    = fin;
          if (fin) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_ALL;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule

// File: rtl/two_class_fifo_ordered_drain.sv
// Adds (drop) and queries: the result is registered and is on out_* in the cycle after accept.
// Drains: accept moves the controller to S_DRAIN; items then go to the output register
// one item per cycle while out_tready holds; in_tready stays low until the last item is in
// the output register. Adds and queries: one word per cycle while out_tready holds.
// Reset: synchronous, clears queue pointers, fill counts, arrival stamp and
// output valid; queue storage is not cleared and is never read before written.
// ----------------------------------------------------------------------------
// two_class_fifo_ordered_drain
// Two class FIFOs with shared arrival stamps; drain-all in global arrival order.
// ----------------------------------------------------------------------------
module two_class_fifo_ordered_drain #(
  parameter int QUEUE_DEPTH = tcfod_pkg::QUEUE_DEPTH_DEF,
  parameter int STAMP_BITS  = tcfod_pkg::STAMP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tcfod_pkg::IN_TDATA_W-1:0]    in_tdata,   // action[2:0], ident[34:3], zero pad
  input  logic                                in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tcfod_pkg::OUT_TDATA_W-1:0]   out_tdata,  // status[1:0], out_ident[33:2], zero pad
  output logic                                out_tuser,  // out_kind
  output logic                                out_tlast   // last
);
  import tcfod_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  action_t            action;
  logic [IDENT_W-1:0] in_ident;
  status_t            out_status;
  logic [IDENT_W-1:0] out_ident;

  assign action   = action_t'(in_tdata[ACTION_W-1:0]);
  assign in_ident = in_tdata[ACTION_W +: IDENT_W];

  tcfod_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .action   (action),
    .kind     (in_tuser),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  tcfod_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .STAMP_BITS(STAMP_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_ident   (in_ident),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_kind   (out_tuser),
    .out_ident  (out_ident),
    .out_last   (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W-STATUS_W-IDENT_W)'(0), out_ident, out_status};

endmodule

// File: rtl/tcfod_checker.sv
// ----------------------------------------------------------------------------
// tcfod_checker
// Port-level checks for two_class_fifo_ordered_drain, bound to the top level.
// ----------------------------------------------------------------------------
module tcfod_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [tcfod_pkg::IN_TDATA_W-1:0]    in_tdata,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [tcfod_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                                out_tuser,
  input logic                                out_tlast
);
  import tcfod_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // no new word taken while the output register is blocked
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output blocked");

  // a query answers in the next cycle with a single final word
  a_query_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[ACTION_W-1:0] == ACT_Q_BOTH
      || in_tdata[ACTION_W-1:0] == ACT_Q_C0 || in_tdata[ACTION_W-1:0] == ACT_Q_C1)
    |=> out_tvalid && out_tlast && (out_tdata[STATUS_W-1:0] == ST_YES
      || out_tdata[STATUS_W-1:0] == ST_NO))
    else $error("query answer missing");

  // only drained items continue a run
  a_nonlast_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[STATUS_W-1:0] == ST_DRAINED)
    else $error("non-final word is not a drained item");

  // answers carry no class or identifier
  a_answer_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STATUS_W-1:0] == ST_YES || out_tdata[STATUS_W-1:0] == ST_NO)
    |-> !out_tuser && out_tdata[STATUS_W +: IDENT_W] == '0)
    else $error("answer word carries payload");

endmodule

bind two_class_fifo_ordered_drain tcfod_checker u_tcfod_checker (.*);
